@@ rtl/wdt2_pkg.sv @@
// Shared types, register map and constants for the two-stage watchdog.
// No dependencies; imported by wdt2_core and the top level.
`default_nettype none

package wdt2_pkg;

    // Item kinds on the input stream
    typedef enum logic [1:0] {
        KIND_TICK  = 2'd0,
        KIND_READ  = 2'd1,
        KIND_WRITE = 2'd2,
        KIND_NONE  = 2'd3
    } t_kind;

    // Access status codes returned with each result
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BAD_ADDR  = 2'd1,
        ST_CLOCK_OFF = 2'd2,
        ST_READ_ONLY = 2'd3
    } t_status;

    localparam int IDX_W  = 5;
    localparam int WORD_W = 32;

    // Dense register map
    localparam logic [IDX_W-1:0] REG_LOAD     = 5'd0;
    localparam logic [IDX_W-1:0] REG_VALUE    = 5'd1;
    localparam logic [IDX_W-1:0] REG_CTL      = 5'd2;
    localparam logic [IDX_W-1:0] REG_ICR      = 5'd3;
    localparam logic [IDX_W-1:0] REG_RIS      = 5'd4;
    localparam logic [IDX_W-1:0] REG_MIS      = 5'd5;
    localparam logic [IDX_W-1:0] REG_TEST     = 5'd6;
    localparam logic [IDX_W-1:0] REG_LOCK     = 5'd7;
    localparam logic [IDX_W-1:0] REG_ID_FIRST = 5'd8;
    localparam logic [IDX_W-1:0] REG_ID_LAST  = 5'd19;

    // Reset values
    localparam logic [WORD_W-1:0] WORD_ONES      = 32'hFFFF_FFFF;
    localparam logic [WORD_W-1:0] CTL_SECOND_RST = 32'h8000_0000;

    // Control bits
    localparam int CTL_INTEN_BIT = 0;
    localparam int CTL_RESEN_BIT = 1;

    typedef struct packed {
        t_kind              kind;
        logic [IDX_W-1:0]   reg_index;
        logic [WORD_W-1:0]  write_data;
    } t_item;

    typedef struct packed {
        logic [WORD_W-1:0]  read_data;
        logic               interrupt_pulse;
        logic               reset_request;
        t_status            access_status;
    } t_result;

    // Peripheral and cell ID words, offset from REG_ID_FIRST
    function automatic logic [WORD_W-1:0] id_word(input logic [3:0] offs);
        logic [WORD_W-1:0] w;
        case (offs)
            4'd4:    w = 32'h0000_0005;
            4'd5:    w = 32'h0000_0018;
            4'd6:    w = 32'h0000_0018;
            4'd7:    w = 32'h0000_0001;
            4'd8:    w = 32'h0000_000D;
            4'd9:    w = 32'h0000_00F0;
            4'd10:   w = 32'h0000_0006;
            4'd11:   w = 32'h0000_00B1;
            default: w = '0;
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

@@ rtl/two_stage_watchdog_timer_core.sv @@
// Two-stage watchdog top level: input register, core logic, result register.
// Each item is held in the input register, then its result in the result register.
// Throughput: one item per cycle; the result register frees up as it is taken,
// so a stalled output only holds the input register once both are full.
// Reset (i_rst_n low, synchronous) empties both registers, gates the module
// clock off and restores all watchdog registers. Depends on wdt2_pkg, wdt2_core.
`default_nettype none

module two_stage_watchdog_timer_core #(
    parameter bit SECOND_INSTANCE = 1'b0
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    // Input stream
    input  wire         i_s_tvalid,
    output logic        o_s_tready,
    input  wire  [39:0] i_s_tdata,   // [4:0] reg_index, [36:5] write_data, rest zero
    input  wire  [1:0]  i_s_tuser,   // [1:0] kind
    // Result stream
    output logic        o_m_tvalid,
    input  wire         i_m_tready,
    output logic [39:0] o_m_tdata,   // [31:0] read_data, [32] interrupt_pulse,
                                     // [33] reset_request, rest zero
    output logic [1:0]  o_m_tuser,   // [1:0] access_status
    // Configuration: module clock enable
    input  wire         i_cfg_valid,
    output logic        o_cfg_ready,
    input  wire         i_cfg_data
);
    import wdt2_pkg::*;

    logic    r_in_valid;
    t_item   r_in_item;
    logic    r_out_valid;
    t_result r_out;
    logic    r_clk_en;
    t_result core_result;
    logic    fire;

    // Item moves from input register to result register
    assign fire       = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || fire;
    assign o_cfg_ready = 1'b1;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_tvalid && o_s_tready) begin
            r_in_item.kind       <= t_kind'(i_s_tuser);
            r_in_item.reg_index  <= i_s_tdata[IDX_W-1:0];
            r_in_item.write_data <= i_s_tdata[IDX_W+WORD_W-1:IDX_W];
        end
    end

    // Module clock gate register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clk_en <= 1'b0;
        end else if (i_cfg_valid) begin
            r_clk_en <= i_cfg_data;
        end
    end

    wdt2_core #(
        .SECOND_INSTANCE (SECOND_INSTANCE)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_clk_en (r_clk_en),
        .i_item   (r_in_item),
        .o_result (core_result)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out <= core_result;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {6'd0, r_out.reset_request, r_out.interrupt_pulse, r_out.read_data};
    assign o_m_tuser  = r_out.access_status;

endmodule

`default_nettype wire

@@ rtl/wdt2_core.sv @@
// Watchdog register file, countdown and timeout logic for one item per cycle while i_fire commits.
// Depends on wdt2_pkg.
`default_nettype none

module wdt2_core #(
    parameter bit SECOND_INSTANCE = 1'b0
) (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_fire,      // commit the registered item
    input  wire             i_clk_en,    // module clock gate
    input  wire wdt2_pkg::t_item i_item,
    output wdt2_pkg::t_result o_result
);
    import wdt2_pkg::*;

    localparam logic [WORD_W-1:0] CTL_RST = SECOND_INSTANCE ? CTL_SECOND_RST : '0;

    logic [WORD_W-1:0] r_load, n_load;
    logic [WORD_W-1:0] r_cnt, n_cnt;
    logic              r_counting, n_counting;
    logic [WORD_W-1:0] r_ctl, n_ctl;
    logic [WORD_W-1:0] r_icr, n_icr;
    logic              r_ris, n_ris;
    logic              r_mis, n_mis;
    logic [WORD_W-1:0] r_test, n_test;
    logic [3:0]        id_offs;

    assign id_offs = 4'(i_item.reg_index - REG_ID_FIRST);

    // Next state and result for the item in the input register
    always_comb begin
        n_load     = r_load;
        n_cnt      = r_cnt;
        n_counting = r_counting;
        n_ctl      = r_ctl;
        n_icr      = r_icr;
        n_ris      = r_ris;
        n_mis      = r_mis;
        n_test     = r_test;
        o_result   = '{read_data: '0, interrupt_pulse: 1'b0, reset_request: 1'b0,
                       access_status: ST_OK};

        unique case (i_item.kind)
            KIND_TICK: begin
                if (r_counting) begin
                    if (r_cnt > 32'd1) begin
                        n_cnt = r_cnt - 32'd1;
                    end else begin
                        n_cnt = r_load;
                        if (!r_mis) begin
                            n_ris = 1'b1;
                            n_mis = 1'b1;
                            o_result.interrupt_pulse = 1'b1;
                        end else if (r_ctl[CTL_RESEN_BIT]) begin
                            o_result.reset_request = 1'b1;
                        end else begin
                            o_result.interrupt_pulse = 1'b1;
                        end
                    end
                end
            end
            KIND_READ: begin
                if (!i_clk_en) begin
                    o_result.access_status = ST_CLOCK_OFF;
                end else begin
                    case (i_item.reg_index) inside
                        REG_LOAD:  o_result.read_data = r_load;
                        REG_VALUE: o_result.read_data = r_cnt;
                        REG_CTL:   o_result.read_data = r_ctl;
                        REG_ICR:   o_result.read_data = r_icr;
                        REG_RIS:   o_result.read_data = {{(WORD_W-1){1'b0}}, r_ris};
                        REG_MIS:   o_result.read_data = {{(WORD_W-1){1'b0}}, r_mis};
                        REG_TEST:  o_result.read_data = r_test;
                        REG_LOCK:  o_result.read_data = '0;
                        [REG_ID_FIRST:REG_ID_LAST]:
                            o_result.read_data = id_word(id_offs);
                        default:   o_result.access_status = ST_BAD_ADDR;
                    endcase
                end
            end
            KIND_WRITE: begin
                if (!i_clk_en) begin
                    o_result.access_status = ST_CLOCK_OFF;
                end else begin
                    case (i_item.reg_index) inside
                        REG_LOAD: begin
                            n_load             = i_item.write_data;
                            n_ctl[CTL_INTEN_BIT] = 1'b1;
                            n_cnt              = i_item.write_data;
                            n_counting         = 1'b1;
                        end
                        REG_CTL:  n_ctl = i_item.write_data;
                        REG_ICR: begin
                            n_cnt = r_load;
                            n_ris = 1'b0;
                            n_mis = 1'b0;
                            n_icr = i_item.write_data;
                        end
                        REG_TEST: n_test = i_item.write_data;
                        REG_LOCK: ;  // accepted, no effect
                        REG_VALUE, REG_RIS, REG_MIS, [REG_ID_FIRST:REG_ID_LAST]:
                            o_result.access_status = ST_READ_ONLY;
                        default:  o_result.access_status = ST_BAD_ADDR;
                    endcase
                end
            end
            default: ;  // unused kind: no effect, zero result
        endcase
    end

    // State registers, committed when the item moves to the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_load     <= WORD_ONES;
            r_cnt      <= WORD_ONES;
            r_counting <= 1'b0;
            r_ctl      <= CTL_RST;
            r_icr      <= '0;
            r_ris      <= 1'b0;
            r_mis      <= 1'b0;
            r_test     <= '0;
        end else if (i_fire) begin
            r_load     <= n_load;
            r_cnt      <= n_cnt;
            r_counting <= n_counting;
            r_ctl      <= n_ctl;
            r_icr      <= n_icr;
            r_ris      <= n_ris;
            r_mis      <= n_mis;
            r_test     <= n_test;
        end
    end

`ifndef SYNTHESIS
    // Reset request only after a first timeout with reset enabled
    a_rst_needs_mis: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.reset_request |-> (r_mis && r_ctl[CTL_RESEN_BIT]))
        else $error("reset request without pending masked status");

    // A timeout raises exactly one of interrupt or reset
    a_one_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_result.interrupt_pulse && o_result.reset_request))
        else $error("interrupt and reset request together");

    // A committed first timeout leaves the status set
    a_first_sets_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && o_result.interrupt_pulse && !r_mis) |=> (r_mis && r_ris))
        else $error("first timeout did not set status");

    // Events only on ticks while counting
    a_event_on_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result.interrupt_pulse || o_result.reset_request)
            |-> (i_item.kind == KIND_TICK && r_counting))
        else $error("timeout outside a counting tick");
`endif

endmodule

`default_nettype wire
